>>> hdl/assert_macros.svh
// Assertion helpers used by drfp_scan.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

>>> hdl/drfp_pkg.sv
`default_nettype none
package drfp_pkg;

    localparam int FRAME_DEPTH_DEF = 64;

    // Frame layout and reply constants.
    localparam logic [7:0] HDR_FIRST      = 8'h5A;
    localparam logic [7:0] HDR_SECOND     = 8'hA5;
    localparam logic [7:0] CMD_WRITE_ACK  = 8'h82;
    localparam logic [7:0] CMD_READ_REPLY = 8'h83;
    localparam logic [7:0] ACK_CHAR_O     = 8'h4F;
    localparam logic [7:0] ACK_CHAR_K     = 8'h4B;
    localparam logic [7:0] DATA_STOP      = 8'hFF;

    localparam int POS_HDR_FIRST  = 0;
    localparam int POS_HDR_SECOND = 1;
    localparam int POS_CMD        = 3;
    localparam int POS_ARG_HI     = 4;
    localparam int POS_ARG_LO     = 5;
    localparam int POS_WORDS      = 6;
    localparam int DATA_START     = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_MIN_FRAME_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd2;

    localparam logic [6:0] MIN_FRAME_LEN_RST = 7'd6;
    localparam logic [6:0] MAX_FRAME_LEN_RST = 7'd64;

    typedef enum logic [2:0] {
        ST_BAD_LEN   = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_BAD_CMD   = 3'd2,
        ST_ACK_OK    = 3'd3,
        ST_ACK_BAD   = 3'd4,
        ST_READ_DATA = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    typedef enum logic {
        SC_IDLE = 1'b0,
        SC_SCAN = 1'b1
    } t_scan_state;

    typedef struct packed {
        t_status     status;
        logic [15:0] var_address;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        run_last;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/display_response_frame_parser_core.sv
`default_nettype none
// Response frame parser for a serial touch display. Bytes of one frame are
// taken one per clock (start high while busy is low) and written into the frame
// memory; busy stays low while a frame arrives. The byte marked as frame end is
// taken the same way. A frame that fails the length window gives its single
// result in the next cycle without raising busy. Otherwise busy stays high
// while the frame memory is scanned through its one read port, one byte per
// cycle: each result shows once the scan has judged the byte that decides it,
// a header byte, the command byte or the acknowledge argument, and the last
// result of a read reply shows once the scan reaches the end of its data.
// Results come one per cycle on o_strobe and must be taken as they appear,
// since the receiver cannot hold them off; the last result of a frame carries
// o_run_last.
module display_response_frame_parser_core #(
    parameter int FRAME_DEPTH = drfp_pkg::FRAME_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_frame_end,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [15:0] o_var_address,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_run_last
);
    import drfp_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic          r_key_enable;
    logic [6:0]    r_min_frame_len;
    logic [6:0]    r_max_frame_len;
    logic          w_accept;
    logic [7:0]    w_rd_data;
    logic [CW-1:0] w_rd_addr;
    logic [CW-1:0] w_len_fin;
    logic          w_ovf_fin;
    t_result       w_result;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable    <= 1'b1;
            r_min_frame_len <= MIN_FRAME_LEN_RST;
            r_max_frame_len <= MAX_FRAME_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_ENABLE:    r_key_enable    <= i_cfg_data[0];
                CFG_MIN_FRAME_LEN: r_min_frame_len <= i_cfg_data;
                CFG_MAX_FRAME_LEN: r_max_frame_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    drfp_store #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept),
        .i_wr_last (i_frame_end),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (w_rd_addr[AW-1:0]),
        .o_rd_data (w_rd_data),
        .o_len_fin (w_len_fin),
        .o_ovf_fin (w_ovf_fin)
    );

    drfp_scan #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_frame_end     (i_frame_end),
        .i_len_fin       (w_len_fin),
        .i_ovf_fin       (w_ovf_fin),
        .i_key_enable    (r_key_enable),
        .i_min_frame_len (r_min_frame_len),
        .i_max_frame_len (r_max_frame_len),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data),
        .o_busy          (busy),
        .o_strobe        (o_strobe),
        .o_result        (w_result)
    );

    assign o_status      = w_result.status;
    assign o_var_address = w_result.var_address;
    assign o_data_byte   = w_result.data_byte;
    assign o_data_valid  = w_result.data_valid;
    assign o_run_last    = w_result.run_last;

endmodule
`default_nettype wire

>>> hdl/drfp_store.sv
`default_nettype none
module drfp_store #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_wr_en,
    input  wire                                 i_wr_last,
    input  wire  [7:0]                          i_wr_data,
    input  wire  [$clog2(FRAME_DEPTH)-1:0]      i_rd_addr,
    output logic [7:0]                          o_rd_data,
    output logic [$clog2(FRAME_DEPTH+1)-1:0]    o_len_fin,
    output logic                                o_ovf_fin
);
    import drfp_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic [7:0]    r_frame_store [FRAME_DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          w_room;

    assign w_room    = (r_count < CW'(FRAME_DEPTH));
    assign o_len_fin = r_count + CW'(w_room);
    assign o_ovf_fin = r_ovf | ~w_room;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_wr_en) begin
            if (i_wr_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_room) begin
            r_frame_store[r_count[AW-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_frame_store[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/drfp_scan.sv
`default_nettype none
`include "assert_macros.svh"
module drfp_scan #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  wire                                 i_frame_end,
    input  wire  [$clog2(FRAME_DEPTH+1)-1:0]    i_len_fin,
    input  wire                                 i_ovf_fin,
    input  wire                                 i_key_enable,
    input  wire  [6:0]                          i_min_frame_len,
    input  wire  [6:0]                          i_max_frame_len,
    output logic [$clog2(FRAME_DEPTH+1)-1:0]    o_rd_addr,
    input  wire  [7:0]                          i_rd_data,
    output logic                                o_busy,
    output logic                                o_strobe,
    output drfp_pkg::t_result                   o_result
);
    import drfp_pkg::*;

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int EW = (CW > 10) ? CW : 10;

    t_scan_state   r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_q, n_q;
    logic          r_qv, n_qv;
    logic [CW-1:0] r_len, n_len;
    logic          r_is_ack, n_is_ack;
    logic [7:0]    r_arg_hi, n_arg_hi;
    logic [15:0]   r_addr, n_addr;
    logic [EW-1:0] r_dend, n_dend;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_d, n_pend_d;
    logic          r_strobe, n_strobe;
    t_result       r_res, n_res;

    logic [7:0]    w_byte;
    logic          w_bad_len;
    logic          w_stop;

    // Bytes past the end of this frame read as zero.
    assign w_byte    = (r_q < r_len) ? i_rd_data : 8'h00;
    assign w_bad_len = i_ovf_fin
                    || (LW'(i_len_fin) < LW'(i_min_frame_len))
                    || (LW'(i_len_fin) > LW'(i_max_frame_len));
    assign w_stop    = (EW'(r_q) >= r_dend) || (r_q >= r_len) || (w_byte == DATA_STOP);

    assign o_rd_addr = r_ptr;
    assign o_busy    = (r_state != SC_IDLE);
    assign o_strobe  = r_strobe;
    assign o_result  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SC_IDLE;
            r_qv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qv     <= n_qv;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_q      <= n_q;
        r_len    <= n_len;
        r_is_ack <= n_is_ack;
        r_arg_hi <= n_arg_hi;
        r_addr   <= n_addr;
        r_dend   <= n_dend;
        r_pend_d <= n_pend_d;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_q      = r_q;
        n_qv     = 1'b0;
        n_len    = r_len;
        n_is_ack = r_is_ack;
        n_arg_hi = r_arg_hi;
        n_addr   = r_addr;
        n_dend   = r_dend;
        n_pend_v = r_pend_v;
        n_pend_d = r_pend_d;
        n_strobe = 1'b0;
        n_res    = '0;
        n_res.run_last = 1'b1;

        unique case (r_state)
            SC_IDLE: begin
                if (i_accept && i_frame_end) begin
                    if (w_bad_len) begin
                        n_strobe     = 1'b1;
                        n_res.status = ST_BAD_LEN;
                    end else begin
                        n_state  = SC_SCAN;
                        n_ptr    = '0;
                        n_len    = i_len_fin;
                        n_pend_v = 1'b0;
                        n_is_ack = 1'b0;
                        n_addr   = '0;
                        n_dend   = '0;
                    end
                end
            end
            SC_SCAN: begin
                // One memory read per cycle; the byte of the previous address is judged.
                n_ptr = r_ptr + CW'(1);
                n_q   = r_ptr;
                n_qv  = 1'b1;
                if (r_qv) begin
                    if (r_q == CW'(POS_HDR_FIRST)) begin
                        if (w_byte != HDR_FIRST) begin
                            n_strobe     = 1'b1;
                            n_res.status = ST_BAD_HDR;
                            n_state      = SC_IDLE;
                            n_qv         = 1'b0;
                        end
                    end else if (r_q == CW'(POS_HDR_SECOND)) begin
                        if (w_byte != HDR_SECOND) begin
                            n_strobe     = 1'b1;
                            n_res.status = ST_BAD_HDR;
                            n_state      = SC_IDLE;
                            n_qv         = 1'b0;
                        end
                    end else if (r_q == CW'(POS_CMD)) begin
                        if (w_byte == CMD_WRITE_ACK) begin
                            n_is_ack = 1'b1;
                        end else if (w_byte != CMD_READ_REPLY) begin
                            n_strobe     = 1'b1;
                            n_res.status = ST_BAD_CMD;
                            n_state      = SC_IDLE;
                            n_qv         = 1'b0;
                        end else if (!i_key_enable) begin
                            n_strobe     = 1'b1;
                            n_res.status = ST_IGNORED;
                            n_state      = SC_IDLE;
                            n_qv         = 1'b0;
                        end
                    end else if (r_q == CW'(POS_ARG_HI)) begin
                        n_arg_hi = w_byte;
                    end else if (r_q == CW'(POS_ARG_LO)) begin
                        if (r_is_ack) begin
                            n_strobe     = 1'b1;
                            n_res.status = (r_arg_hi == ACK_CHAR_O && w_byte == ACK_CHAR_K)
                                         ? ST_ACK_OK : ST_ACK_BAD;
                            n_state      = SC_IDLE;
                            n_qv         = 1'b0;
                        end else begin
                            n_addr = {r_arg_hi, w_byte};
                        end
                    end else if (r_q == CW'(POS_WORDS)) begin
                        n_dend = EW'({w_byte, 1'b0}) + EW'(DATA_START);
                    end else if (r_q >= CW'(DATA_START)) begin
                        // A data byte is held back one step so that the last one
                        // can carry the end-of-run mark.
                        n_res.status      = ST_READ_DATA;
                        n_res.var_address = r_addr;
                        if (w_stop) begin
                            n_strobe         = 1'b1;
                            n_res.data_byte  = r_pend_v ? r_pend_d : 8'h00;
                            n_res.data_valid = r_pend_v;
                            n_state          = SC_IDLE;
                            n_qv             = 1'b0;
                            n_pend_v         = 1'b0;
                        end else begin
                            n_strobe         = r_pend_v;
                            n_res.data_byte  = r_pend_d;
                            n_res.data_valid = 1'b1;
                            n_res.run_last   = 1'b0;
                            n_pend_v         = 1'b1;
                            n_pend_d         = w_byte;
                        end
                    end
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, r_strobe && !r_res.run_last, r_strobe)
    `ASSERT_IMPL(a_partial_in_scan, i_clk, i_rst_n, r_strobe && !r_res.run_last, r_state == SC_SCAN)
    `ASSERT_IMPL(a_data_is_read, i_clk, i_rst_n, r_strobe && r_res.data_valid, r_res.status == ST_READ_DATA)
    `ASSERT_IMPL(a_scan_in_frame, i_clk, i_rst_n, r_qv, (LW'(r_q) <= LW'(r_len)) || (r_q <= CW'(DATA_START)))

endmodule
`default_nettype wire
